// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers, sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/paids_pkg.sv -----
// ----------------------------------------------------------------------------
// paids_pkg
// shared types and constants of the packed array insert/delete/stats block
// ----------------------------------------------------------------------------
package paids_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 7;
	localparam int CNT_W     = 7;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_REVERSE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SH_UP,
		S_SH_DN,
		S_REV_A,
		S_REV_B,
		S_REV_C,
		S_REV_D,
		S_SCAN,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] largest;
		logic signed [DATA_W-1:0] smallest;
		logic signed [DATA_W-1:0] mean;
		logic [CNT_W-1:0]         count;
		status_t                  status;
	} res_t;

endpackage

// ----- design/paids_div.sv -----
// ----------------------------------------------------------------------------
// paids_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module paids_div
	import paids_pkg::*;
#(
	parameter int SW = DATA_W + $clog2(DEPTH_DEF),
	parameter int FW = $clog2(DEPTH_DEF + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SW-1:0]     dividend,
	input  logic [FW-1:0]            divisor,
	output logic                     done,
	output logic signed [DATA_W-1:0] quotient
);

	localparam int CNTW = $clog2(SW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNTW-1:0]   cnt_q;
	logic              neg_q;
	logic [SW-1:0]     num_q;
	logic [FW-1:0]     rem_q;
	logic [FW-1:0]     dvs_q;
	logic [SW-1:0]     mag;
	logic [FW:0]       trial;
	logic [FW:0]       diff;
	logic              ge;
	logic [DATA_W-1:0] qmag;

	assign mag   = dividend[SW-1] ? $unsigned(-dividend) : $unsigned(dividend);
	assign trial = {rem_q, num_q[SW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitude shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			num_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[SW-2:0], ge};
			rem_q <= ge ? diff[FW-1:0] : trial[FW-1:0];
		end
	end

	assign qmag     = num_q[DATA_W-1:0];
	assign quotient = $signed(neg_q ? DATA_W'(-qmag) : qmag);
	assign done     = done_q;

endmodule

// ----- design/packed_array_insert_delete_stats.sv -----
// ----------------------------------------------------------------------------
// packed_array_insert_delete_stats
// packed signed array with insert, delete, reverse and max/min/mean report
// ----------------------------------------------------------------------------
// One request at a time; cmd_stall stays high until the result is handed to
// the output register. Entries live in a single-port-write, single-port-read
// memory, so entry moves, swaps and statistics reads go through it one at a
// time. An insert shifts the entries from position upward to open a gap, a
// delete shifts the entries above position down, and a reverse swaps pairs
// from both ends inward. Every request then scans all count entries and, on
// a non-empty array, runs the bit-serial divider for the mean; the result is
// handed over while the output register is free.
`include "assert_macros.svh"

module packed_array_insert_delete_stats
	import paids_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > POS_W) ? FW : POS_W;
	localparam int SW = DATA_W + AW;

	state_t                   state_q, state_d;
	logic [FW-1:0]            fill_q;
	logic [FW-1:0]            ptr_q;
	logic [FW-1:0]            stop_q;
	logic [AW-1:0]            hi_q;
	logic                     pend_q;
	logic [AW-1:0]            pend_addr_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] tmp_q;
	logic signed [DATA_W-1:0] rd_data_q;
	logic                     rej_q;
	logic                     first_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [SW-1:0]     sum_q;
	logic                     res_valid_q;
	res_t                     res_q;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	logic                     cmd_fire;
	logic [CW-1:0]            pos_x;
	logic [CW-1:0]            fill_x;
	logic                     ins_ok;
	logic                     del_ok;
	logic [FW-1:0]            ptr_m1;
	logic [FW-1:0]            fill_m1;
	logic                     up_rd;
	logic                     below_fill;
	logic                     rev_more;
	logic                     scan_start;
	logic                     ins_done;
	logic                     out_free;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                     div_start;
	logic                     div_done;
	logic signed [DATA_W-1:0] div_quot;

	assign cmd_stall  = (state_q != S_IDLE);
	assign cmd_fire   = cmd_valid && !cmd_stall;
	assign pos_x      = CW'(cmd.position);
	assign fill_x     = CW'(fill_q);
	assign ins_ok     = (fill_x < CW'(DEPTH)) && (pos_x <= fill_x);
	assign del_ok     = (fill_q != '0) && (pos_x < fill_x);
	assign ptr_m1     = ptr_q - FW'(1);
	assign fill_m1    = fill_q - FW'(1);
	assign up_rd      = ptr_q > stop_q;
	assign below_fill = ptr_q < fill_q;
	assign rev_more   = (ptr_q + FW'(2)) < FW'(hi_q);
	assign scan_start = (state_d == S_SCAN) && (state_q != S_SCAN);
	assign ins_done   = (state_q == S_SH_UP) && (state_d == S_SCAN);
	assign out_free   = !res_valid_q || !res_stall;
	assign div_start  = (state_q == S_SCAN) && (state_d == S_DIV);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					unique case (cmd.operation)
						OP_INSERT:  state_d = ins_ok ? S_SH_UP : S_SCAN;
						OP_DELETE:  state_d = del_ok ? S_SH_DN : S_SCAN;
						OP_REVERSE: state_d = (fill_q >= FW'(2)) ? S_REV_A : S_SCAN;
						OP_QUERY:   state_d = S_SCAN;
						default:    state_d = S_SCAN;
					endcase
				end
			end
			S_SH_UP: if (!pend_q && !up_rd) state_d = S_SCAN;
			S_SH_DN: if (!pend_q && !below_fill) state_d = S_SCAN;
			S_REV_A: state_d = S_REV_B;
			S_REV_B: state_d = S_REV_C;
			S_REV_C: state_d = S_REV_D;
			S_REV_D: state_d = rev_more ? S_REV_A : S_SCAN;
			S_SCAN: begin
				if (!pend_q && !below_fill) state_d = (fill_q == '0) ? S_DONE : S_DIV;
			end
			S_DIV:   if (div_done) state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_addr = ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = rd_data_q;
		unique case (state_q)
			S_SH_UP: begin
				rd_addr = ptr_m1[AW-1:0];
				if (pend_q) begin
					wr_en = 1'b1;
				end else if (!up_rd) begin
					// gap is open, drop the new value in
					wr_en   = 1'b1;
					wr_addr = ptr_q[AW-1:0];
					wr_data = val_q;
				end
			end
			S_SH_DN: wr_en = pend_q;
			S_REV_B: rd_addr = hi_q;
			S_REV_C: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[AW-1:0];
			end
			S_REV_D: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = tmp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_SH_UP: pend_q <= up_rd;
				S_SH_DN: pend_q <= below_fill;
				S_SCAN:  pend_q <= below_fill;
				default: pend_q <= 1'b0;
			endcase
			if (ins_done) fill_q <= fill_q + FW'(1);
			if ((state_q == S_SH_DN) && (state_d == S_SCAN)) fill_q <= fill_m1;
			if ((state_q == S_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					val_q  <= cmd.value;
					stop_q <= pos_x[FW-1:0];
					hi_q   <= fill_m1[AW-1:0];
					rej_q  <= ((cmd.operation == OP_INSERT) && !ins_ok) ||
					          ((cmd.operation == OP_DELETE) && !del_ok);
					if (!scan_start) begin
						if (cmd.operation == OP_INSERT) begin
							ptr_q <= fill_q;
						end else if (cmd.operation == OP_DELETE) begin
							ptr_q <= pos_x[FW-1:0] + FW'(1);
						end else begin
							ptr_q <= '0;
						end
					end
				end
			end
			S_SH_UP: begin
				if (up_rd) begin
					ptr_q       <= ptr_m1;
					pend_addr_q <= ptr_q[AW-1:0];
				end
			end
			S_SH_DN: begin
				if (below_fill) begin
					ptr_q       <= ptr_q + FW'(1);
					pend_addr_q <= ptr_m1[AW-1:0];
				end
			end
			S_REV_B: tmp_q <= rd_data_q;
			S_REV_D: begin
				if (rev_more) ptr_q <= ptr_q + FW'(1);
				hi_q <= hi_q - AW'(1);
			end
			S_SCAN: begin
				if (below_fill) ptr_q <= ptr_q + FW'(1);
				if (pend_q) begin
					if (first_q) begin
						max_q   <= rd_data_q;
						min_q   <= rd_data_q;
						sum_q   <= SW'(rd_data_q);
						first_q <= 1'b0;
					end else begin
						if (rd_data_q > max_q) max_q <= rd_data_q;
						if (rd_data_q < min_q) min_q <= rd_data_q;
						sum_q <= sum_q + SW'(rd_data_q);
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_q.largest  <= max_q;
					res_q.smallest <= min_q;
					res_q.mean     <= (fill_q == '0) ? '0 : div_quot;
					res_q.count    <= CNT_W'(fill_q);
					if (rej_q) begin
						res_q.status <= ST_REJECT;
					end else if (fill_q == '0) begin
						res_q.status <= ST_EMPTY;
					end else begin
						res_q.status <= ST_OK;
					end
				end
			end
			default: ;
		endcase
		// empty array keeps the zeros loaded here
		if (scan_start) begin
			ptr_q   <= '0;
			first_q <= 1'b1;
			max_q   <= '0;
			min_q   <= '0;
			sum_q   <= '0;
		end
	end

	paids_div #(
		.SW(SW),
		.FW(FW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_ALWAYS(a_fill_le_depth, fill_q <= FW'(DEPTH), "fill count beyond depth")
	`ASSERT_ALWAYS(a_res_from_done, $rose(res_valid_q) |-> $past(state_q == S_DONE), "stray result")
	`ASSERT_ALWAYS(a_div_done_in_div, div_done |-> (state_q == S_DIV), "divider done outside divide")
	`ASSERT_NEXT(a_insert_grows, ins_done, fill_q == $past(fill_q) + FW'(1), "insert did not grow fill")

endmodule
